// File: design/aie_pkg.sv
// Shared types and constants for the arithmetic interval encoder.
// Used by every module of the block; has no dependencies of its own.
package aie_pkg;

    // Fraction width of the bounds and of the running interval
    localparam int FRAC_W = 32;
    // Width of the symbol code on the input stream
    localparam int SYM_W = 7;
    // Default table depth
    localparam int SYMBOL_COUNT_DEF = 128;
    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Stream payload widths: symbol, bound_low, bound_high, padded to bytes
    localparam int IN_FIELDS_W = SYM_W + FRAC_W + FRAC_W + 1;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((FRAC_W + 7) / 8) * 8;

    // 1.0 as an unsigned fraction
    localparam logic [FRAC_W:0] ONE_VALUE = {1'b1, {FRAC_W{1'b0}}};

    // Item kinds carried in tuser
    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_ENCODE = 1'b1
    } t_op;

    // Interval unit sequencer
    typedef enum logic {
        BK_IDLE,
        BK_ADD
    } t_back_state;

    // Looked-up encode item passed from front to back
    typedef struct packed {
        logic [FRAC_W-1:0] lo;
        logic [FRAC_W:0]   hi;
        logic              known;
        logic              last;
    } t_sym_item;

    // Queue fill status seen by both neighbours
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: design/aie_front.sv
// Front end: accepts stream transfers, cleans and stores table writes,
// looks up encode symbols. Depends on aie_pkg.
module aie_front #(
    parameter int SYMBOL_COUNT = aie_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_op,
    input  logic [aie_pkg::SYM_W-1:0]  i_symbol,
    input  logic [aie_pkg::FRAC_W-1:0] i_bound_low,
    input  logic [aie_pkg::FRAC_W:0]   i_bound_high,
    input  logic                       i_last,
    output logic                       o_push_valid,
    output aie_pkg::t_sym_item         o_push_item,
    input  aie_pkg::t_q_status         i_q_status
);

    localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    // Bound table and its valid bits
    logic [aie_pkg::FRAC_W-1:0] r_tab_lo [SYMBOL_COUNT];
    logic [aie_pkg::FRAC_W:0]   r_tab_hi [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0]    r_tab_valid;

    // Lookup stage
    logic                       r_st_valid;
    logic                       n_st_valid;
    logic [aie_pkg::FRAC_W-1:0] r_st_lo;
    logic [aie_pkg::FRAC_W:0]   r_st_hi;
    logic                       r_st_known;
    logic                       r_st_last;

    logic                       w_accept;
    logic                       w_acc_write;
    logic                       w_acc_enc;
    logic                       w_in_range;
    logic [IDX_W-1:0]           w_idx;
    logic [aie_pkg::FRAC_W:0]   w_hi_sat;
    logic [aie_pkg::FRAC_W-1:0] w_lo_clip;

    // Accept while the stage is empty or drains into the queue this cycle
    assign o_ready     = !r_st_valid || !i_q_status.full;
    assign w_accept    = i_valid && o_ready;
    assign w_acc_write = w_accept && (i_op == aie_pkg::OP_WRITE);
    assign w_acc_enc   = w_accept && (i_op == aie_pkg::OP_ENCODE);

    assign w_in_range = (32'(i_symbol) < SYMBOL_COUNT);
    assign w_idx      = IDX_W'(i_symbol);

    // Saturate the upper bound to one, clip the lower bound to the upper
    always_comb begin
        w_hi_sat = i_bound_high;
        if (i_bound_high > aie_pkg::ONE_VALUE) begin
            w_hi_sat = aie_pkg::ONE_VALUE;
        end
        w_lo_clip = i_bound_low;
        if ({1'b0, i_bound_low} > w_hi_sat) begin
            w_lo_clip = w_hi_sat[aie_pkg::FRAC_W-1:0];
        end
    end

    // Table write and registered lookup read
    always_ff @(posedge i_clk) begin
        if (w_acc_write && w_in_range) begin
            r_tab_lo[w_idx] <= w_lo_clip;
            r_tab_hi[w_idx] <= w_hi_sat;
        end
        if (w_acc_enc) begin
            r_st_lo <= r_tab_lo[w_idx];
            r_st_hi <= r_tab_hi[w_idx];
        end
    end

    // Valid bits and lookup flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_valid <= '0;
        end else if (w_acc_write && w_in_range) begin
            r_tab_valid[w_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_enc) begin
            r_st_known <= w_in_range && r_tab_valid[w_idx];
            r_st_last  <= i_last;
        end
    end

    // Hold the stage until the queue takes it
    always_comb begin
        n_st_valid = r_st_valid;
        if (w_acc_enc) begin
            n_st_valid = 1'b1;
        end else if (r_st_valid && !i_q_status.full) begin
            n_st_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_valid <= 1'b0;
        end else begin
            r_st_valid <= n_st_valid;
        end
    end

    assign o_push_valid      = r_st_valid;
    assign o_push_item.lo    = r_st_lo;
    assign o_push_item.hi    = r_st_hi;
    assign o_push_item.known = r_st_known;
    assign o_push_item.last  = r_st_last;

endmodule

// File: design/aie_queue.sv
// Short queue of looked-up encode items between front and back.
// Depends on aie_pkg for the item type and depth.
module aie_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  aie_pkg::t_sym_item i_item,
    input  logic               i_pop,
    output aie_pkg::t_sym_item o_head,
    output aie_pkg::t_q_status o_status
);

    localparam int DEPTH = aie_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    aie_pkg::t_sym_item r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_do_push      = i_push && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;
    assign o_head         = r_slot[r_rd_ptr];

    // Store an entry on push
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/aie_back.sv
// Back end: narrows the running interval in a multiply state and an add state
// per symbol, and holds the code word in an output register. Depends on aie_pkg.
module aie_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  aie_pkg::t_sym_item         i_head,
    input  aie_pkg::t_q_status         i_q_status,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [aie_pkg::FRAC_W-1:0] o_code,
    output logic                       o_unknown
);

    localparam int FW  = aie_pkg::FRAC_W;
    localparam int PW  = 2 * FW + 2;

    aie_pkg::t_back_state r_state, n_state;

    logic [FW-1:0] r_low,   n_low;
    logic [FW:0]   r_range, n_range;
    logic          r_err,   n_err;
    logic [FW:0]   r_plo_s, n_plo_s;
    logic [FW:0]   r_phi_s, n_phi_s;
    logic          r_known, n_known;
    logic          r_last,  n_last;
    logic          r_out_valid, n_out_valid;
    logic [FW-1:0] r_code,  n_code;
    logic          r_unknown, n_unknown;

    logic [PW-1:0] w_plo;
    logic [PW-1:0] w_phi;
    logic [FW:0]   w_sum_low;
    logic          w_fin_ok;

    // Scale the current range by both symbol bounds
    assign w_plo = PW'(r_range) * PW'(i_head.lo);
    assign w_phi = PW'(r_range) * PW'(i_head.hi);

    assign w_sum_low = {1'b0, r_low} + r_plo_s;
    assign w_fin_ok  = !r_last || !r_out_valid || i_ready;

    // Sequence: take a symbol and multiply, then add and maybe emit
    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_range     = r_range;
        n_err       = r_err;
        n_plo_s     = r_plo_s;
        n_phi_s     = r_phi_s;
        n_known     = r_known;
        n_last      = r_last;
        n_code      = r_code;
        n_unknown   = r_unknown;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;
        case (r_state)
            aie_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_plo_s = w_plo[2*FW:FW];
                    n_phi_s = w_phi[2*FW:FW];
                    n_known = i_head.known;
                    n_last  = i_head.last;
                    n_state = aie_pkg::BK_ADD;
                end
            end
            aie_pkg::BK_ADD: begin
                if (w_fin_ok) begin
                    n_state = aie_pkg::BK_IDLE;
                    if (r_known) begin
                        n_low   = w_sum_low[FW-1:0];
                        n_range = r_phi_s - r_plo_s;
                    end else begin
                        n_err = 1'b1;
                    end
                    // Emit the code word and return to [0, 1)
                    if (r_last) begin
                        n_out_valid = 1'b1;
                        n_code      = r_known ? w_sum_low[FW-1:0] : r_low;
                        n_unknown   = r_err || !r_known;
                        n_low       = '0;
                        n_range     = aie_pkg::ONE_VALUE;
                        n_err       = 1'b0;
                    end
                end
            end
            default: begin
                n_state = aie_pkg::BK_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aie_pkg::BK_IDLE;
            r_low       <= '0;
            r_range     <= aie_pkg::ONE_VALUE;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_low       <= n_low;
            r_range     <= n_range;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_plo_s   <= n_plo_s;
        r_phi_s   <= n_phi_s;
        r_known   <= n_known;
        r_last    <= n_last;
        r_code    <= n_code;
        r_unknown <= n_unknown;
    end

    assign o_valid   = r_out_valid;
    assign o_code    = r_code;
    assign o_unknown = r_unknown;

endmodule

// File: design/arithmetic_interval_encoder.sv
// Top level of the arithmetic interval encoder.
// Instantiates aie_front, aie_queue and aie_back; depends on aie_pkg.
//
// Input stream: tuser selects the item kind (0 loads a table entry with a
// symbol's cumulative bounds, 1 encodes a symbol); tlast marks the final
// symbol of a message. Table writes are taken one per cycle while tready is high and
// never give a result. Each encode narrows the running interval; the final symbol
// of a message yields one output transfer with the code word in tdata and
// an unknown-symbol flag in tuser, after which the interval is [0, 1).
// The back end takes one encode at a time through the interval loop (multiply
// state, then add state, the next symbol needing the new range). After the edge that
// accepts a final symbol, the lookup read is registered, then the item passes through
// the queue, the multiply state and the add state before output valid rises.
// A four-entry queue lets the front keep accepting while the back works.
// Reset empties the queue, clears all table entries to invalid and sets
// the interval to [0, 1); no clearing pass is needed.
// While the receiver stalls, the code word is held in the output register;
// the back end stops only when a second code word is ready, and the front
// stalls once the queue fills.
module arithmetic_interval_encoder #(
    parameter int SYMBOL_COUNT = aie_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // symbol [6:0], bound_low [38:7], bound_high [71:39]
    input  logic [aie_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // operation
    input  logic                           i_s_axis_tuser,
    input  logic                           i_s_axis_tlast,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // code_value [31:0]
    output logic [aie_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // unknown_symbol
    output logic                           o_m_axis_tuser
);

    localparam int SW = aie_pkg::SYM_W;
    localparam int FW = aie_pkg::FRAC_W;

    logic                w_push_valid;
    aie_pkg::t_sym_item  w_push_item;
    aie_pkg::t_sym_item  w_head;
    aie_pkg::t_q_status  w_q_status;
    logic                w_pop;
    logic [FW-1:0]       w_code;

    aie_front #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_op         (i_s_axis_tuser),
        .i_symbol     (i_s_axis_tdata[SW-1:0]),
        .i_bound_low  (i_s_axis_tdata[SW+FW-1:SW]),
        .i_bound_high (i_s_axis_tdata[SW+2*FW:SW+FW]),
        .i_last       (i_s_axis_tlast),
        .o_push_valid (w_push_valid),
        .o_push_item  (w_push_item),
        .i_q_status   (w_q_status)
    );

    aie_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push_valid),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    aie_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_code     (w_code),
        .o_unknown  (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = aie_pkg::OUT_DATA_W'(w_code);

    // The back end never takes from an empty queue
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty queue");

    // Each symbol holds the interval unit through its multiply and add states
    a_pop_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> !w_pop)
        else $error("symbols popped on consecutive cycles");

    // The input side stalls only behind a full queue
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> w_q_status.full && w_push_valid)
        else $error("input stalled with room in the queue");

endmodule

// File: tb/arithmetic_interval_encoder_test.sv
// Self-checking testbench for arithmetic_interval_encoder: table writes and encode messages
// drive the input stream, and code words on the output stream are checked against an
// in-bench interval predictor. Depends on aie_pkg and the design sources.
module arithmetic_interval_encoder_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int REPORT_LIMIT   = 10;
    // Symbols kept out of every table write, so encodes of them stay unknown
    localparam int RESERVED_FIRST = 100;
    localparam int RESERVED_LAST  = 111;

    typedef struct {
        logic [aie_pkg::FRAC_W-1:0] code;
        logic                       unknown;
    } t_code_word;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [aie_pkg::IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                           i_s_axis_tuser = 1'b0;
    logic                           i_s_axis_tlast = 1'b0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [aie_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                           o_m_axis_tuser;

    // Predictor state: running interval, symbol table and error flag
    logic [aie_pkg::FRAC_W:0]   run_low = '0;
    logic [aie_pkg::FRAC_W:0]   run_high = aie_pkg::ONE_VALUE;
    logic [aie_pkg::FRAC_W-1:0] tbl_lo [aie_pkg::SYMBOL_COUNT_DEF];
    logic [aie_pkg::FRAC_W:0]   tbl_hi [aie_pkg::SYMBOL_COUNT_DEF];
    bit                         tbl_valid [aie_pkg::SYMBOL_COUNT_DEF];
    bit                         err_seen = 1'b0;

    t_code_word expected_codes[$];

    int  fail_count = 0;
    int  report_count = 0;
    int  stall_cycles = 0;
    int  burst_left = 0;
    int  rx_run_left = 0;
    bit  tx_steady = 1'b1;
    bit  rx_steady = 1'b1;

    arithmetic_interval_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Update the table or narrow the interval for one accepted transfer
    task automatic predict_code_word(input aie_pkg::t_op op,
                                     input logic [aie_pkg::SYM_W-1:0] sym,
                                     input logic [aie_pkg::FRAC_W-1:0] blo,
                                     input logic [aie_pkg::FRAC_W:0] bhi, input logic last);
        logic [aie_pkg::FRAC_W:0]     lo_b;
        logic [aie_pkg::FRAC_W:0]     hi_b;
        logic [aie_pkg::FRAC_W:0]     rng;
        logic [2*aie_pkg::FRAC_W+1:0] prod_lo;
        logic [2*aie_pkg::FRAC_W+1:0] prod_hi;
        t_code_word                   cw;
        if (op == aie_pkg::OP_WRITE) begin
            // saturate above one, then clamp a reversed pair to the upper bound
            hi_b = (bhi > aie_pkg::ONE_VALUE) ? aie_pkg::ONE_VALUE : bhi;
            lo_b = {1'b0, blo};
            if (lo_b > hi_b) lo_b = hi_b;
            tbl_lo[sym]    = lo_b[aie_pkg::FRAC_W-1:0];
            tbl_hi[sym]    = hi_b;
            tbl_valid[sym] = 1'b1;
        end else begin
            if (tbl_valid[sym]) begin
                rng      = run_high - run_low;
                prod_lo  = rng * tbl_lo[sym];
                prod_hi  = rng * tbl_hi[sym];
                run_high = run_low + prod_hi[2*aie_pkg::FRAC_W:aie_pkg::FRAC_W];
                run_low  = run_low + prod_lo[2*aie_pkg::FRAC_W:aie_pkg::FRAC_W];
            end else begin
                err_seen = 1'b1;
            end
            if (last) begin
                cw.code    = run_low[aie_pkg::FRAC_W-1:0];
                cw.unknown = err_seen;
                expected_codes.push_back(cw);
                run_low  = '0;
                run_high = aie_pkg::ONE_VALUE;
                err_seen = 1'b0;
            end
        end
    endtask

    // Present one item, hold it until the transfer, then predict it
    task automatic send_item(input aie_pkg::t_op op, input logic [aie_pkg::SYM_W-1:0] sym,
                             input logic [aie_pkg::FRAC_W-1:0] blo,
                             input logic [aie_pkg::FRAC_W:0] bhi, input logic last);
        int gap_len;
        if (!tx_steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_len    = $urandom_range(1, 8);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap_len) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {bhi, blo, sym};
        i_s_axis_tuser  <= op;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        predict_code_word(op, sym, blo, bhi, last);
    endtask

    function automatic bit is_reserved(input int sym);
        return sym >= RESERVED_FIRST && sym <= RESERVED_LAST;
    endfunction

    function automatic logic [aie_pkg::SYM_W-1:0] pick_write_symbol();
        int sym;
        do sym = $urandom_range(0, aie_pkg::SYMBOL_COUNT_DEF - 1); while (is_reserved(sym));
        return aie_pkg::SYM_W'(sym);
    endfunction

    function automatic logic [aie_pkg::SYM_W-1:0] pick_known_symbol();
        int sym;
        do sym = $urandom_range(0, aie_pkg::SYMBOL_COUNT_DEF - 1);
        while (!tbl_valid[sym] || is_reserved(sym));
        return aie_pkg::SYM_W'(sym);
    endfunction

    function automatic logic [aie_pkg::FRAC_W:0] rand_bound_high();
        return {1'($urandom), 32'($urandom)};
    endfunction

    // Encodes before any table write: every symbol is unknown
    task automatic test_unknown_after_reset();
        send_item(aie_pkg::OP_ENCODE, 7'd0, 32'd0, 33'd0, 1'b1);
        send_item(aie_pkg::OP_ENCODE, 7'd127, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF, 1'b0);
        send_item(aie_pkg::OP_ENCODE, 7'd5, 32'd0, 33'd0, 1'b1);
    endtask

    // Bound corners: full interval, top sliver, saturation, reversal, empty entry
    task automatic test_bound_corners();
        send_item(aie_pkg::OP_WRITE, 7'd0, 32'd0, aie_pkg::ONE_VALUE, 1'b0);
        send_item(aie_pkg::OP_WRITE, 7'd127, 32'hFFFF_FFFF, aie_pkg::ONE_VALUE, 1'b0);
        send_item(aie_pkg::OP_WRITE, 7'd1, 32'h4000_0000, 33'h1_FFFF_FFFF, 1'b0);
        send_item(aie_pkg::OP_WRITE, 7'd2, 32'h8000_0000, 33'h0_4000_0000, 1'b0);
        send_item(aie_pkg::OP_WRITE, 7'd3, 32'h1234_5678, 33'h0_1234_5678, 1'b0);
        // last flag on a write gives no result
        send_item(aie_pkg::OP_WRITE, 7'd64, 32'h2000_0000, 33'h0_A000_0000, 1'b1);
        send_item(aie_pkg::OP_ENCODE, 7'd0, 32'd0, 33'd0, 1'b1);
        send_item(aie_pkg::OP_ENCODE, 7'd127, 32'd0, 33'd0, 1'b1);
        send_item(aie_pkg::OP_ENCODE, 7'd1, 32'd0, 33'd0, 1'b1);
        send_item(aie_pkg::OP_ENCODE, 7'd2, 32'd0, 33'd0, 1'b1);
        send_item(aie_pkg::OP_ENCODE, 7'd3, 32'd0, 33'd0, 1'b1);
        send_item(aie_pkg::OP_ENCODE, 7'd64, 32'd0, 33'd0, 1'b1);
    endtask

    // Multi-symbol messages, one with an unknown symbol in the middle
    task automatic test_message_mix();
        send_item(aie_pkg::OP_ENCODE, 7'd64, 32'd0, 33'd0, 1'b0);
        send_item(aie_pkg::OP_ENCODE, 7'd1, 32'd0, 33'd0, 1'b0);
        send_item(aie_pkg::OP_ENCODE, 7'd127, 32'd0, 33'd0, 1'b1);
        send_item(aie_pkg::OP_ENCODE, 7'd1, 32'd0, 33'd0, 1'b0);
        send_item(aie_pkg::OP_ENCODE, 7'd105, 32'd0, 33'd0, 1'b0);
        send_item(aie_pkg::OP_ENCODE, 7'd64, 32'd0, 33'd0, 1'b1);
    endtask

    // Mostly well-formed table loads and messages, with some raw noise writes
    task automatic run_random_traffic(input int count);
        int sent;
        int kind;
        int len;
        int bad_pos;
        logic [aie_pkg::FRAC_W-1:0] lo;
        logic [63:0] span;
        logic [aie_pkg::FRAC_W:0] hi;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                // reload a handful of entries with ordered bounds
                len = $urandom_range(1, 6);
                repeat (len) begin
                    lo   = $urandom;
                    span = 64'(aie_pkg::ONE_VALUE) - 64'(lo) + 64'd1;
                    hi   = 33'(64'(lo) + ({32'($urandom), 32'($urandom)} % span));
                    send_item(aie_pkg::OP_WRITE, pick_write_symbol(), lo, hi,
                              1'($urandom));
                    sent++;
                end
            end else if (kind < 85) begin
                len = $urandom_range(1, 8);
                for (int j = 0; j < len; j++) begin
                    send_item(aie_pkg::OP_ENCODE, pick_known_symbol(), $urandom,
                              rand_bound_high(), j == len - 1);
                    sent++;
                end
            end else if (kind < 93) begin
                // message broken by one unknown symbol
                len     = $urandom_range(1, 5);
                bad_pos = $urandom_range(0, len - 1);
                for (int j = 0; j < len; j++) begin
                    send_item(aie_pkg::OP_ENCODE,
                              (j == bad_pos) ?
                                  aie_pkg::SYM_W'($urandom_range(RESERVED_FIRST,
                                                                 RESERVED_LAST))
                                  : pick_known_symbol(),
                              $urandom, rand_bound_high(), j == len - 1);
                    sent++;
                end
            end else begin
                // raw bounds: saturation and reversal happen often here
                send_item(aie_pkg::OP_WRITE, pick_write_symbol(), $urandom,
                          rand_bound_high(), 1'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_random_back_to_back();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_random_traffic(150);
    endtask

    task automatic test_random_sender_gaps();
        tx_steady = 1'b0;
        rx_steady = 1'b1;
        run_random_traffic(150);
    endtask

    task automatic test_random_receiver_stalls();
        tx_steady = 1'b1;
        rx_steady = 1'b0;
        run_random_traffic(200);
    endtask

    task automatic test_random_full_idling();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        run_random_traffic(400);
    endtask

    // Receiver: alternate runs of ready and stall of random length
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (rx_steady) begin
            i_m_axis_tready <= 1'b1;
        end else if (rx_run_left == 0) begin
            i_m_axis_tready <= !i_m_axis_tready;
            if (i_m_axis_tready)
                rx_run_left = ($urandom_range(0, 15) == 0) ? 30 : $urandom_range(1, 12);
            else
                rx_run_left = $urandom_range(1, 10);
        end else begin
            rx_run_left--;
        end
    end

    // Compare each output transfer with the oldest expected code word
    always @(posedge i_clk) begin
        t_code_word cw;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_codes.size() == 0) begin
                fail_count++;
                if (report_count < REPORT_LIMIT)
                    $display("unexpected code word %h unknown %b",
                             o_m_axis_tdata[aie_pkg::FRAC_W-1:0], o_m_axis_tuser);
                report_count++;
            end else begin
                cw = expected_codes.pop_front();
                if (o_m_axis_tdata[aie_pkg::FRAC_W-1:0] !== cw.code ||
                    o_m_axis_tuser !== cw.unknown) begin
                    fail_count++;
                    if (report_count < REPORT_LIMIT)
                        $display("code word mismatch: expected %h unknown %b, got %h unknown %b",
                                 cw.code, cw.unknown, o_m_axis_tdata[aie_pkg::FRAC_W-1:0],
                                 o_m_axis_tuser);
                    report_count++;
                end
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("arithmetic_interval_encoder regression: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_unknown_after_reset();
        test_bound_corners();
        test_message_mix();
        test_random_back_to_back();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_full_idling();
        i_s_axis_tvalid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("arithmetic_interval_encoder regression: pass");
        else
            $display("arithmetic_interval_encoder regression: fail");
        $finish;
    end

endmodule
